// ===== rtl/hkmc_pkg.sv =====
`default_nettype none
package hkmc_pkg;
  localparam int unsigned Buckets = 1024;
  localparam int unsigned Entries = 4096;
  localparam int unsigned BucketW = $clog2(Buckets);
  localparam int unsigned EntryW = $clog2(Entries);
  localparam int unsigned LinkW = $clog2(Entries + 1);
  localparam int unsigned KeyW = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned SumW = 63;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    StClear, StIdle, StHead, StRead, StCmp, StOut
  } state_e;

  typedef struct packed {
    logic clear;
    logic load_key;
    logic read_head;
    logic read_entry;
    logic do_hit;
    logic do_insert;
    logic do_full;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic link_zero;
    logic key_match;
    logic table_full;
    logic steps_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/hkmc_ctrl.sv =====
`default_nettype none
module hkmc_ctrl import hkmc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  stat_t stat_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (stat_i.clear_done) state_d = StIdle;
      StIdle: if (in_valid_i) state_d = StHead;
      StHead: state_d = StRead;
      StRead: begin
        if (stat_i.link_zero || stat_i.steps_done) state_d = StOut;
        else state_d = StCmp;
      end
      StCmp: begin
        if (stat_i.key_match) state_d = StOut;
        else state_d = StRead;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StClear: cmd_o.clear = 1'b1;
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_key = in_valid_i;
      end
      StHead: cmd_o.read_head = 1'b1;
      StRead: begin
        if (stat_i.link_zero || stat_i.steps_done) begin
          cmd_o.do_full = stat_i.table_full;
          cmd_o.do_insert = !stat_i.table_full;
        end else begin
          cmd_o.read_entry = 1'b1;
        end
      end
      StCmp: begin
        cmd_o.do_hit = stat_i.key_match;
        cmd_o.advance = !stat_i.key_match;
      end
      StOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/hkmc_datapath.sv =====
`default_nettype none
module hkmc_datapath import hkmc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  [KeyW-1:0] key_i,
  input  cmd_t cmd_i,
  output stat_t stat_o,
  output logic [CountW-1:0] multiplicity_o,
  output logic [SumW-1:0] square_sum_o,
  output logic table_full_o
);
  // Heads are cleared one bucket per cycle by a pass that runs after reset.
  logic [LinkW-1:0] head_mem [Buckets];
  logic [KeyW-1:0] ekey_mem [Entries];
  logic [CountW-1:0] ecnt_mem [Entries];
  logic [LinkW-1:0] enext_mem [Entries];

  logic [BucketW-1:0] clr_q;
  logic [KeyW-1:0] key_q;
  logic [LinkW-1:0] link_q, head_q;
  logic [LinkW-1:0] used_q;
  logic [LinkW:0] steps_q;
  logic [SumW-1:0] sum_q;
  logic [KeyW-1:0] rkey_q;
  logic [CountW-1:0] rcnt_q;
  logic [LinkW-1:0] rnext_q;
  logic [CountW-1:0] mult_q;
  logic full_q;
  logic [BucketW-1:0] bucket;
  logic [EntryW-1:0] eidx;
  logic [SumW+1:0] add_amt, sum_wide;
  logic [SumW-1:0] sum_d;

  assign bucket = key_q[BucketW-1:0];
  assign eidx = EntryW'(link_q - LinkW'(1));

  assign stat_o.clear_done = (clr_q == BucketW'(Buckets - 1));
  assign stat_o.link_zero = (link_q == '0);
  assign stat_o.key_match = (rkey_q == key_q);
  assign stat_o.table_full = (used_q >= LinkW'(Entries));
  assign stat_o.steps_done = (steps_q >= (LinkW+1)'(Entries));

  always_comb begin
    if (cmd_i.do_hit) add_amt = (SumW+2)'({rcnt_q, 1'b1});
    else add_amt = (SumW+2)'(1);
    sum_wide = {2'b00, sum_q} + add_amt;
    sum_d = (sum_wide >= {2'b00, SumMax}) ? SumMax : sum_wide[SumW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) head_mem[clr_q] <= '0;
    if (cmd_i.load_key) key_q <= key_i;
    if (cmd_i.read_head) head_q <= head_mem[bucket];
    if (cmd_i.read_entry) begin
      rkey_q <= ekey_mem[eidx];
      rcnt_q <= ecnt_mem[eidx];
      rnext_q <= enext_mem[eidx];
    end
    if (cmd_i.do_hit) begin
      mult_q <= (rcnt_q == CountMax) ? rcnt_q : rcnt_q + CountW'(1);
      ecnt_mem[eidx] <= (rcnt_q == CountMax) ? rcnt_q : rcnt_q + CountW'(1);
    end
    if (cmd_i.do_insert) begin
      ekey_mem[used_q[EntryW-1:0]] <= key_q;
      ecnt_mem[used_q[EntryW-1:0]] <= CountW'(1);
      enext_mem[used_q[EntryW-1:0]] <= head_q;
      head_mem[bucket] <= used_q + LinkW'(1);
      mult_q <= CountW'(1);
    end
    if (cmd_i.do_full) mult_q <= '0;
  end

  // The walk link: loaded from the head, then followed entry by entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      used_q <= '0;
      sum_q <= '0;
      full_q <= 1'b0;
      link_q <= '0;
      steps_q <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + BucketW'(1);
      if (cmd_i.load_key) steps_q <= '0;
      if (cmd_i.read_head) link_q <= head_mem[bucket];
      if (cmd_i.advance) begin
        link_q <= rnext_q;
        steps_q <= steps_q + (LinkW+1)'(1);
      end
      if (cmd_i.do_hit) begin
        sum_q <= sum_d;
        full_q <= 1'b0;
      end
      if (cmd_i.do_insert) begin
        used_q <= used_q + LinkW'(1);
        sum_q <= sum_d;
        full_q <= 1'b0;
      end
      if (cmd_i.do_full) full_q <= 1'b1;
    end
  end

  assign multiplicity_o = mult_q;
  assign square_sum_o = sum_q;
  assign table_full_o = full_q;
endmodule
`default_nettype wire

// ===== rtl/hash_key_multiplicity_counter.sv =====
// Counts occurrences of 64-bit keys in a chained hash table of 4096 entries
// over 1024 buckets (bucket = low ten key bits), and keeps a saturating sum
// of squared multiplicities.
// Input channel: in_valid_i/in_ready_o with key_i. Output channel:
// out_valid_o/out_ready_i with multiplicity_o, square_sum_o, table_full_o.
// One item is processed at a time. The chain walk, one memory read and one
// key compare per entry, sets the latency. After acceptance the bucket head
// is read, then each chain entry is read and its key compared, until a match,
// the chain end or the walk bound is reached; then the result is offered.
// After the result is taken, the block returns to idle before it accepts the
// next key.
// A new key is linked at the chain front; when all entries are used a new
// key is dropped with multiplicity 0 and table_full 1.
// Reset clears the entry count and the sum, then a clearing pass writes the
// 1024 bucket heads one per cycle; the block is ready once that pass ends.
// While the receiver stalls, the result is held and no item is accepted.
`default_nettype none
module hash_key_multiplicity_counter import hkmc_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire  [KeyW-1:0] key_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output logic [CountW-1:0] multiplicity_o,
  output logic [SumW-1:0] square_sum_o,
  output logic table_full_o
);
  cmd_t cmd;
  stat_t stat;

  hkmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  hkmc_datapath u_dp (
    .clk_i, .rst_ni, .key_i, .cmd_i(cmd), .stat_o(stat),
    .multiplicity_o, .square_sum_o, .table_full_o
  );
endmodule
`default_nettype wire

// ===== rtl/hkmc_checker.sv =====
`default_nettype none
module hkmc_checker import hkmc_pkg::*; (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_o,
  input wire out_valid_o,
  input wire out_ready_i,
  input wire [CountW-1:0] multiplicity_o,
  input wire [SumW-1:0] square_sum_o,
  input wire table_full_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(square_sum_o))
    else $error("result dropped while stalled");
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during result");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> multiplicity_o == '0)
    else $error("full result with count");
  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> square_sum_o >= $past(square_sum_o))
    else $error("sum decreased");
endmodule

bind hash_key_multiplicity_counter hkmc_checker u_chk (.*);
`default_nettype wire

// ===== verif/tb_hash_key_multiplicity_counter.sv =====
`default_nettype none
module tb_hash_key_multiplicity_counter;
  import hkmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Software image of the hash table. A new key takes the next free entry
  // and is linked in at the front of its bucket's chain.
  class key_count_board;
    int unsigned          head_link[Buckets];
    logic [KeyW-1:0]      slot_key[Entries];
    logic [CountW-1:0]    slot_count[Entries];
    int unsigned          slot_next[Entries];
    int unsigned          slots_used;
    logic [SumW-1:0]      sq_total;
    logic [CountW-1:0]    want_mult[$];
    logic [SumW-1:0]      want_sum[$];
    logic                 want_full[$];
    int unsigned          errors;

    function void add_to_total(logic [64:0] amount);
      logic [64:0] room;
      room = {2'b0, SumMax} - {2'b0, sq_total};
      if (amount >= room) sq_total = SumMax;
      else sq_total = sq_total + amount[SumW-1:0];
    endfunction

    function void note_key(logic [KeyW-1:0] key);
      int unsigned bkt, link, steps, e;
      logic [CountW-1:0] cnt;
      bkt = 32'(key % Buckets);
      link = head_link[bkt];
      steps = 0;
      while (link != 0 && steps < Entries) begin
        e = link - 1;
        if (slot_key[e] == key) begin
          cnt = slot_count[e];
          add_to_total(({33'b0, cnt} << 1) + 65'd1);
          if (cnt != CountMax) slot_count[e] = cnt + 1;
          want_mult.push_back(slot_count[e]);
          want_sum.push_back(sq_total);
          want_full.push_back(1'b0);
          return;
        end
        link = slot_next[e];
        steps++;
      end
      if (slots_used >= Entries) begin
        want_mult.push_back('0);
        want_sum.push_back(sq_total);
        want_full.push_back(1'b1);
        return;
      end
      e = slots_used;
      slot_key[e] = key;
      slot_count[e] = 1;
      slot_next[e] = head_link[bkt];
      head_link[bkt] = e + 1;
      slots_used = e + 1;
      add_to_total(65'd1);
      want_mult.push_back(1);
      want_sum.push_back(sq_total);
      want_full.push_back(1'b0);
    endfunction

    function void check_result(logic [CountW-1:0] m, logic [SumW-1:0] s, logic f);
      logic [CountW-1:0] em;
      logic [SumW-1:0] es;
      logic ef;
      if (want_mult.size() == 0) begin
        $error("result with no pending expectation: mult=%0d", m);
        errors++;
        return;
      end
      em = want_mult.pop_front();
      es = want_sum.pop_front();
      ef = want_full.pop_front();
      if (m !== em) begin
        $error("multiplicity expected %0d actual %0d", em, m);
        errors++;
      end
      if (s !== es) begin
        $error("square_sum expected %0d actual %0d", es, s);
        errors++;
      end
      if (f !== ef) begin
        $error("table_full expected %0d actual %0d", ef, f);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return want_mult.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [KeyW-1:0]   key_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CountW-1:0] multiplicity_o;
  logic [SumW-1:0]   square_sum_o;
  logic              table_full_o;

  key_count_board board;

  // Idle percentages for the two sides; the stimulus process changes them
  // per phase. A nonzero hold_off makes the receiver stall for that many
  // cycles in its own process.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off;
  longint unsigned cycle_count;

  // Keys for the random part are drawn from a small pool most of the time
  // so that repeats, long chains and count growth are exercised.
  logic [KeyW-1:0] key_pool[64];

  hash_key_multiplicity_counter u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .key_i(key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .multiplicity_o(multiplicity_o),
    .square_sum_o(square_sum_o),
    .table_full_o(table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one key, idling first at the current rate, and hold it until the
  // block accepts it. The expectation is noted at the accepting edge. Valid
  // stays high after acceptance unless the next call idles first.
  task automatic send_key(logic [KeyW-1:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_key(key);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return key_pool[$urandom_range(63)];
    // Same bucket as a pool key but a different upper part: chain collisions.
    if (r < 80) return {rand_key()} & ~64'(Buckets - 1) | (key_pool[$urandom_range(7)] % Buckets);
    return rand_key();
  endfunction

  // Receiver: result fields are sampled at the edge where valid and ready
  // are both high, so the check never races the block's outputs.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_result(multiplicity_o, square_sum_o, table_full_o);
      if (hold_off != 0) begin
        out_ready_i <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: each item takes its chain walk plus the random gaps, so this
  // bound is many times the slowest correct run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 64'd2_000_000) begin
        $display("hash_key_multiplicity_counter verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [KeyW-1:0] k;
    board = new();
    in_valid_i = 1'b0;
    key_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 0;
    for (int i = 0; i < 64; i++) key_pool[i] = rand_key();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extreme keys, a repeat, and keys that collide in a
    // bucket so that a hit must be found behind a newer chain entry.
    send_idle_pct = 30;
    recv_idle_pct = 30;
    send_key('0);
    send_key('1);
    send_key('0);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h0000_0000_0000_0400);
    send_key(64'h0000_0000_0000_0800);
    send_key(64'h0000_0000_0000_0400);
    send_key('0);
    send_key('1);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h0000_0000_0000_03FF);
    send_key(64'hFFFF_FFFF_FFFF_FBFF);
    send_key(64'h0000_0000_0000_03FF);
    send_key(64'h8000_0000_0000_0000);
    for (int i = 0; i < 6; i++) send_key(64'h0000_0000_0000_0C00);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 65; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 65; end
        default: begin send_idle_pct = 6; recv_idle_pct = 6; end
      endcase
      // A long receiver hold-off while the sender keeps offering keys back
      // to back, so the block backs up and stalls its input.
      if (ph == 2) hold_off = 300;
      for (int i = 0; i < 120; i++) send_key(pick_key());
    end

    // A last mix of fresh keys and known keys.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    for (int i = 0; i < 40; i++) begin
      k = ($urandom_range(1)) ? rand_key() : key_pool[$urandom_range(63)];
      send_key(k);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("hash_key_multiplicity_counter verification clean");
    end else begin
      $display("hash_key_multiplicity_counter verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/hkmc_pkg.sv
rtl/hkmc_ctrl.sv
rtl/hkmc_datapath.sv
rtl/hash_key_multiplicity_counter.sv
rtl/hkmc_checker.sv
verif/tb_hash_key_multiplicity_counter.sv
